@@ sv/sffs_pkg.sv @@
// Shared types and constants for the spreading factor fan-out scheduler.
package sffs_pkg;

	localparam logic [1:0] CMD_BCAST  = 2'd0;
	localparam logic [1:0] CMD_DM     = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_QUEUED  = 3'd0;
	localparam logic [2:0] ST_BRIDGED = 3'd1;
	localparam logic [2:0] ST_DUP     = 3'd2;
	localparam logic [2:0] ST_PORT    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;
	localparam logic [2:0] ST_NOROOM  = 3'd5;
	localparam logic [2:0] ST_TICK    = 3'd6;

	localparam logic [1:0] DLY_RETRY = 2'd0;
	localparam logic [1:0] DLY_MORE  = 2'd1;
	localparam logic [1:0] DLY_IDLE  = 2'd2;

	localparam logic [2:0] REG_MAIN   = 3'd0;
	localparam logic [2:0] REG_SIDE_A = 3'd1;
	localparam logic [2:0] REG_SIDE_B = 3'd2;
	localparam logic [2:0] REG_SIDE_C = 3'd3;
	localparam logic [2:0] REG_TTL    = 3'd4;

	localparam logic [31:0] TTL_RESET = 32'd30000;
	localparam logic [3:0]  SF_LOW    = 4'd5;
	localparam logic [3:0]  SF_HIGH   = 4'd12;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_COMMIT,
		S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_step;
		logic commit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_request;
		logic scan_done;
	} stat_t;

	// One-hot bit for a factor, zero outside 5..12.
	function automatic logic [7:0] factor_bit(input logic [3:0] sf);
		logic [3:0] off;
		off = sf - SF_LOW;
		if (sf < SF_LOW || sf > SF_HIGH) return 8'd0;
		return 8'd1 << off[2:0];
	endfunction

	// Factor for a one-hot bit.
	function automatic logic [3:0] bit_factor(input logic [7:0] b);
		logic [3:0] f;
		f = SF_HIGH;
		for (int i = 7; i >= 0; i--) if (b[i]) f = SF_LOW + 4'(i);
		return f;
	endfunction

endpackage

@@ sv/sffs_ctrl.sv @@
// Controller state machine sequencing one item through the datapath.
module sffs_ctrl import sffs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  logic  skip,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid && !skip) state_d = S_SCAN;
			S_SCAN:   if (stat.scan_done) state_d = S_DECIDE;
			S_DECIDE: state_d = S_COMMIT;
			S_COMMIT: state_d = S_OUT;
			S_OUT:    if (out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready = (state_q == S_IDLE);
		out_valid = (state_q == S_OUT);
		cmd.load = (state_q == S_IDLE) && in_valid && !skip;
		cmd.scan_step = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	ap_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	ap_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready during output");
	ap_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_SCAN) else $error("load lost");

endmodule

@@ sv/sffs_dp.sv @@
// Datapath: dedup ring, queue slots, mask build and tick service.
module sffs_dp import sffs_pkg::*; #(
	parameter int QUEUE_SLOTS = 4,
	parameter int DEDUP_ENTRIES = 16,
	parameter int SIDE_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0]  in_cmd,
	input  logic [31:0] in_id,
	input  logic [3:0]  in_rx,
	input  logic        in_port,
	input  logic        in_bridged,
	input  logic        in_pool,
	input  logic [31:0] in_now,
	output logic [2:0]  status,
	output logic [1:0]  slot,
	output logic [7:0]  queued_mask,
	output logic        tx_valid,
	output logic [31:0] tx_packet_id,
	output logic [3:0]  tx_sf,
	output logic [3:0]  freed_slots,
	output logic [1:0]  next_delay
);

	localparam int DW = (DEDUP_ENTRIES > 1) ? $clog2(DEDUP_ENTRIES) : 1;
	localparam int QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int CW = $clog2(DEDUP_ENTRIES + 1);

	logic [3:0] main_q;
	logic [3:0] side_q [3];
	logic [31:0] ttl_q;

	logic [1:0] cmd_q;
	logic [31:0] id_q, now_q;
	logic [3:0] rx_q;
	logic port_q, bridged_q, pool_q;

	logic [DEDUP_ENTRIES-1:0] rvalid_q;
	logic [31:0] rid_q [DEDUP_ENTRIES];
	logic [31:0] rtime_q [DEDUP_ENTRIES];
	logic [DW-1:0] rptr_q;
	logic [CW-1:0] scan_q;
	logic hit_q;

	logic [QUEUE_SLOTS-1:0] busy_q;
	logic [7:0] pend_q [QUEUE_SLOTS];
	logic [31:0] sid_q [QUEUE_SLOTS];

	// Decided result, held until taken.
	logic [2:0] status_q;
	logic [QW-1:0] slot_q;
	logic [7:0] mask_q;
	logic txv_q;
	logic [31:0] txid_q;
	logic [3:0] txsf_q;
	logic [QUEUE_SLOTS-1:0] freed_q;
	logic [1:0] delay_q;
	logic [QUEUE_SLOTS-1:0] nbusy_q;
	logic [7:0] npend_q;
	logic [QW-1:0] psel_q;
	logic pwr_q, record_q;

	assign stat.is_request = (cmd_q != CMD_TICK);
	assign stat.scan_done = !stat.is_request || bridged_q || hit_q
		|| (scan_q >= CW'(DEDUP_ENTRIES));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_q <= '0;
			side_q <= '{default: '0};
			ttl_q <= TTL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAIN:   main_q <= cfg_data[3:0];
				REG_SIDE_A: side_q[0] <= cfg_data[3:0];
				REG_SIDE_B: side_q[1] <= cfg_data[3:0];
				REG_SIDE_C: side_q[2] <= cfg_data[3:0];
				REG_TTL:    ttl_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Input beat capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_cmd; id_q <= in_id; now_q <= in_now; rx_q <= in_rx;
			port_q <= in_port; bridged_q <= in_bridged; pool_q <= in_pool;
		end
	end

	// Dedup entry under scan; unwritten entries read as zero.
	logic [DW-1:0] sidx;
	logic [31:0] e_id, e_time;
	assign sidx = scan_q[DW-1:0];
	assign e_id = rvalid_q[sidx] ? rid_q[sidx] : 32'd0;
	assign e_time = rvalid_q[sidx] ? rtime_q[sidx] : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.load) begin
			scan_q <= '0;
			hit_q <= 1'b0;
		end else if (cmd.scan_step && !stat.scan_done) begin
			if (e_id == id_q && (now_q - e_time) < ttl_q) hit_q <= 1'b1;
			scan_q <= scan_q + 1'b1;
		end
	end

	// Mask build.
	logic [7:0] mask_c;
	always_comb begin
		mask_c = '0;
		if (cmd_q == CMD_BCAST) begin
			for (int s = 0; s < SIDE_COUNT; s++)
				if (side_q[s] != 0 && side_q[s] != main_q) mask_c |= factor_bit(side_q[s]);
			if (rx_q != main_q) mask_c |= factor_bit(rx_q);
		end else begin
			mask_c = factor_bit(main_q);
			for (int s = 0; s < SIDE_COUNT; s++)
				if (side_q[s] != 0) mask_c |= factor_bit(side_q[s]);
			mask_c &= ~factor_bit(rx_q);
		end
	end

	// First free slot and first busy slot with work pending.
	logic free_f, busy_f;
	logic [QW-1:0] free_i, busy_i;
	always_comb begin
		free_f = 1'b0; free_i = '0; busy_f = 1'b0; busy_i = '0;
		for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin free_f = 1'b1; free_i = QW'(i); end
		end
		for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
			if (busy_q[i] && pend_q[i] != 0) begin busy_f = 1'b1; busy_i = QW'(i); end
		end
	end

	logic [7:0] bpend, lbit;
	assign bpend = pend_q[busy_i];
	assign lbit = bpend & (~bpend + 8'd1);

	// Decide the result and the state update.
	always_ff @(posedge clk) begin
		if (cmd.scan_step && stat.scan_done) begin
			status_q <= ST_TICK; slot_q <= '0; mask_q <= '0; txv_q <= 1'b0;
			txid_q <= '0; txsf_q <= '0; freed_q <= '0; delay_q <= DLY_RETRY;
			nbusy_q <= busy_q; npend_q <= bpend; psel_q <= busy_i;
			pwr_q <= 1'b0; record_q <= 1'b0;
			if (!stat.is_request) begin
				// Slots with nothing pending before the first working slot are freed.
				if (busy_f) begin
					slot_q <= busy_i;
					for (int i = 0; i < QUEUE_SLOTS; i++)
						if (QW'(i) < busy_i && busy_q[i] && pend_q[i] == 0) begin
							nbusy_q[i] <= 1'b0; freed_q[i] <= 1'b1;
						end
				end
				if (busy_f && !pool_q) begin
					delay_q <= DLY_RETRY;
				end else begin
					logic [QUEUE_SLOTS-1:0] nb;
					nb = busy_q;
					for (int i = 0; i < QUEUE_SLOTS; i++)
						if (busy_q[i] && pend_q[i] == 0) nb[i] = 1'b0;
					if (busy_f) begin
						txv_q <= 1'b1; txid_q <= sid_q[busy_i]; txsf_q <= bit_factor(lbit);
						npend_q <= bpend & ~lbit; pwr_q <= 1'b1;
						if ((bpend & ~lbit) == 0) nb[busy_i] = 1'b0;
					end
					nbusy_q <= nb;
					freed_q <= busy_q & ~nb;
					delay_q <= (nb != 0) ? DLY_MORE : DLY_IDLE;
				end
			end else if (bridged_q) begin
				status_q <= ST_BRIDGED; delay_q <= DLY_RETRY;
			end else if (hit_q) begin
				status_q <= ST_DUP;
			end else begin
				record_q <= 1'b1;
				if (cmd_q == CMD_BCAST && !port_q) status_q <= ST_PORT;
				else if (mask_c == 0) status_q <= ST_EMPTY;
				else if (!free_f || !pool_q) status_q <= ST_NOROOM;
				else begin
					status_q <= ST_QUEUED; slot_q <= free_i; mask_q <= mask_c;
					nbusy_q[free_i] <= 1'b1; npend_q <= mask_c; psel_q <= free_i;
					pwr_q <= 1'b1;
				end
			end
		end
	end

	// State update: queue slots and dedup ring.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			rvalid_q <= '0;
			rptr_q <= '0;
		end else if (cmd.commit) begin
			if (!stat.is_request || status_q == ST_QUEUED) busy_q <= nbusy_q;
			if (record_q) begin
				rvalid_q[rptr_q] <= 1'b1;
				rptr_q <= (rptr_q == DW'(DEDUP_ENTRIES - 1)) ? '0 : rptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '{default: '0};
		else if (cmd.commit && pwr_q) pend_q[psel_q] <= npend_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (record_q) begin rid_q[rptr_q] <= id_q; rtime_q[rptr_q] <= now_q; end
			if (status_q == ST_QUEUED && stat.is_request) sid_q[psel_q] <= id_q;
		end
	end

	assign status = status_q;
	assign slot = 2'(slot_q);
	assign queued_mask = mask_q;
	assign tx_valid = txv_q;
	assign tx_packet_id = txid_q;
	assign tx_sf = txsf_q;
	assign freed_slots = 4'(freed_q);
	assign next_delay = stat.is_request ? DLY_RETRY : delay_q;

	ap_tx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && txv_q |-> !stat.is_request) else $error("transmit on request");
	ap_q: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && status_q == ST_QUEUED |-> mask_q != 0) else $error("empty queue");
	ap_rec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && record_q |-> !hit_q && !bridged_q) else $error("bad record");

endmodule

@@ sv/spreading_factor_fanout_scheduler_top.sv @@
// Top level of the spreading factor fan-out scheduler.
// Each accepted request or tick passes through the scan, decide, commit and output
// states. A tick or a bridged request searches no ring entries; for other requests
// the dedup ring is searched one entry per cycle, up to DEDUP_ENTRIES entries,
// stopping at the first live match. Command 3 beats are accepted and produce no
// result. The next beat is accepted once the result has been taken.
module spreading_factor_fanout_scheduler_top import sffs_pkg::*; #(
	parameter int QUEUE_SLOTS = 4,
	parameter int DEDUP_ENTRIES = 16,
	parameter int SIDE_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] packet_id,
	input  logic [3:0]  rx_sf,
	input  logic        port_allowed,
	input  logic        already_bridged,
	input  logic        pool_ok,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  slot,
	output logic [7:0]  queued_mask,
	output logic        tx_valid,
	output logic [31:0] tx_packet_id,
	output logic [3:0]  tx_sf,
	output logic [3:0]  freed_slots,
	output logic [1:0]  next_delay
);

	cmd_t  ctl;
	stat_t st;

	sffs_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.skip(cmd == CMD_UNUSED), .stat(st), .cmd(ctl)
	);

	sffs_dp #(
		.QUEUE_SLOTS(QUEUE_SLOTS), .DEDUP_ENTRIES(DEDUP_ENTRIES), .SIDE_COUNT(SIDE_COUNT)
	) u_dp (
		.clk, .arst_n, .cmd(ctl), .stat(st), .cfg_we, .cfg_index, .cfg_data,
		.in_cmd(cmd), .in_id(packet_id), .in_rx(rx_sf), .in_port(port_allowed),
		.in_bridged(already_bridged), .in_pool(pool_ok), .in_now(now_ms),
		.status, .slot, .queued_mask, .tx_valid, .tx_packet_id, .tx_sf,
		.freed_slots, .next_delay
	);

endmodule

@@ sim/spreading_factor_fanout_scheduler_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the fan-out scheduler: directed and random beats against a scoreboard.
module spreading_factor_fanout_scheduler_top_tb;
	import sffs_pkg::*;

	localparam int SLOTS = 4;
	localparam int RING = 16;
	localparam int DRAIN_CYCLES = RING + 12;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASES = 5;
	localparam int BEATS_PER_PHASE = 215;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] id;
		logic [3:0]  rx;
		logic        port_ok;
		logic        bridged;
		logic        pool_ok;
		logic [31:0] now;
	} relay_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  slot;
		logic [7:0]  qmask;
		logic        txv;
		logic [31:0] txid;
		logic [3:0]  txsf;
		logic [3:0]  freed;
		logic [1:0]  delay;
	} relay_result_t;

	// Scoreboard: mirrors the queue and dedup ring and holds expected results in order.
	class FanoutScoreboard;
		logic [3:0]    main_sf;
		logic [3:0]    side_sf[3];
		logic [31:0]   ttl;
		bit            busy[SLOTS];
		logic [31:0]   pkt_id[SLOTS];
		logic [7:0]    pend[SLOTS];
		logic [31:0]   seen_id[RING];
		logic [31:0]   seen_time[RING];
		int            ring_wr;
		relay_result_t awaited[$];
		int            errors;

		function new();
			main_sf = 0;
			foreach (side_sf[s]) side_sf[s] = 0;
			ttl = TTL_RESET;
			foreach (busy[i]) begin
				busy[i] = 0;
				pkt_id[i] = 0;
				pend[i] = 0;
			end
			foreach (seen_id[i]) begin
				seen_id[i] = 0;
				seen_time[i] = 0;
			end
			ring_wr = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] d);
			case (idx)
				REG_MAIN:   main_sf = d[3:0];
				REG_SIDE_A: side_sf[0] = d[3:0];
				REG_SIDE_B: side_sf[1] = d[3:0];
				REG_SIDE_C: side_sf[2] = d[3:0];
				REG_TTL:    ttl = d;
				default: ;
			endcase
		endfunction

		function logic [7:0] sf_onehot(logic [3:0] sf);
			if (sf < 4'd5 || sf > 4'd12) return 8'd0;
			return 8'd1 << (sf - 4'd5);
		endfunction

		// True if the id is live in the ring; otherwise it is recorded.
		function bit seen_recently(logic [31:0] id, logic [31:0] now);
			logic [31:0] age;
			for (int i = 0; i < RING; i++) begin
				age = now - seen_time[i];
				if (seen_id[i] == id && age < ttl) return 1;
			end
			seen_id[ring_wr] = id;
			seen_time[ring_wr] = now;
			ring_wr = (ring_wr + 1) % RING;
			return 0;
		endfunction

		function void note_beat(relay_beat_t b);
			relay_result_t r;
			logic [7:0] mask, lowbit;
			bit failed, more;
			r = '0;
			if (b.cmd == CMD_UNUSED) return;
			if (b.cmd == CMD_TICK) begin
				failed = 0;
				more = 0;
				r.status = ST_TICK;
				// Service the first busy slot with work, releasing empty ones on the way.
				for (int i = 0; i < SLOTS; i++) begin
					if (!busy[i]) continue;
					if (pend[i] == 0) begin
						busy[i] = 0;
						r.freed[i] = 1'b1;
						continue;
					end
					lowbit = pend[i] & (~pend[i] + 8'd1);
					r.slot = i[1:0];
					if (!b.pool_ok) begin
						failed = 1;
						break;
					end
					pend[i] = pend[i] & ~lowbit;
					r.txv = 1'b1;
					r.txid = pkt_id[i];
					for (int k = 0; k < 8; k++)
						if (lowbit[k]) r.txsf = 4'(k + 5);
					break;
				end
				if (failed) begin
					r.delay = DLY_RETRY;
				end else begin
					for (int i = 0; i < SLOTS; i++) begin
						if (busy[i] && pend[i] == 0) begin
							busy[i] = 0;
							r.freed[i] = 1'b1;
						end
						if (busy[i]) more = 1;
					end
					r.delay = more ? DLY_MORE : DLY_IDLE;
				end
			end else if (b.bridged) begin
				r.status = ST_BRIDGED;
			end else if (seen_recently(b.id, b.now)) begin
				r.status = ST_DUP;
			end else if (b.cmd == CMD_BCAST && !b.port_ok) begin
				r.status = ST_PORT;
			end else begin
				mask = 0;
				if (b.cmd == CMD_BCAST) begin
					foreach (side_sf[s])
						if (side_sf[s] != 0 && side_sf[s] != main_sf) mask |= sf_onehot(side_sf[s]);
					if (b.rx != main_sf) mask |= sf_onehot(b.rx);
				end else begin
					mask = sf_onehot(main_sf);
					foreach (side_sf[s])
						if (side_sf[s] != 0) mask |= sf_onehot(side_sf[s]);
					mask &= ~sf_onehot(b.rx);
				end
				if (mask == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status = ST_NOROOM;
					for (int i = 0; i < SLOTS; i++) begin
						if (!busy[i]) begin
							if (b.pool_ok) begin
								busy[i] = 1;
								pkt_id[i] = b.id;
								pend[i] = mask;
								r.status = ST_QUEUED;
								r.slot = i[1:0];
								r.qmask = mask;
							end
							break;
						end
					end
				end
			end
			awaited.push_back(r);
		endfunction

		function void report(string name, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(relay_result_t a);
			relay_result_t e;
			if (awaited.size() == 0) begin
				$display("%0t unexpected result beat: status %0d", $time, a.status);
				errors++;
				return;
			end
			e = awaited.pop_front();
			report("status", e.status, a.status);
			report("slot", e.slot, a.slot);
			report("queued_mask", e.qmask, a.qmask);
			report("tx_valid", e.txv, a.txv);
			report("tx_packet_id", e.txid, a.txid);
			report("tx_sf", e.txsf, a.txsf);
			report("freed_slots", e.freed, a.freed);
			report("next_delay", e.delay, a.delay);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [31:0] packet_id;
	logic [3:0]  rx_sf;
	logic        port_allowed;
	logic        already_bridged;
	logic        pool_ok;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [1:0]  slot;
	logic [7:0]  queued_mask;
	logic        tx_valid;
	logic [31:0] tx_packet_id;
	logic [3:0]  tx_sf;
	logic [3:0]  freed_slots;
	logic [1:0]  next_delay;

	FanoutScoreboard sb = new();
	bit              calm;
	int              cycles;
	int              stall_left;
	logic [31:0]     uptime;
	logic [31:0]     id_pool[8];

	spreading_factor_fanout_scheduler_top dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("spreading_factor_fanout_scheduler_top_tb: FAIL");
			$finish;
		end
	end

	// Both handshakes are sampled with pre-edge values.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_beat('{cmd, packet_id, rx_sf, port_allowed, already_bridged, pool_ok, now_ms});
		if (arst_n && out_valid && out_ready)
			sb.check_result('{status, slot, queued_mask, tx_valid, tx_packet_id, tx_sf,
				freed_slots, next_delay});
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Result side back-pressure.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			stall_left <= pick_gap();
			out_ready <= 1'b1;
		end
	end

	task automatic send_beat(relay_beat_t b);
		int gap;
		cmd <= b.cmd;
		packet_id <= b.id;
		rx_sf <= b.rx;
		port_allowed <= b.port_ok;
		already_bridged <= b.bridged;
		pool_ok <= b.pool_ok;
		now_ms <= b.now;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender until every result is back and the block has gone quiet.
	task automatic wait_idle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller drops the write enable after the last one.
	task automatic cfg_write(logic [2:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic program_regs(logic [3:0] m, logic [3:0] a, logic [3:0] b, logic [3:0] c,
		logic [31:0] ttl);
		cfg_write(REG_MAIN, {28'd0, m});
		cfg_write(REG_SIDE_A, {28'd0, a});
		cfg_write(REG_SIDE_B, {28'd0, b});
		cfg_write(REG_SIDE_C, {28'd0, c});
		cfg_write(REG_TTL, ttl);
		cfg_we <= 1'b0;
	endtask

	function relay_beat_t mk(logic [1:0] c, logic [31:0] id, logic [3:0] rx, logic port,
		logic br, logic pool, logic [31:0] now);
		return '{c, id, rx, port, br, pool, now};
	endfunction

	// Mostly requests with recurring ids and a slowly moving clock, plus ticks and noise.
	function relay_beat_t random_beat();
		relay_beat_t b;
		int r;
		r = $urandom_range(0, 99);
		b.cmd = (r < 38) ? CMD_BCAST : (r < 62) ? CMD_DM : (r < 96) ? CMD_TICK : CMD_UNUSED;
		b.id = ($urandom_range(0, 1) == 0) ? id_pool[$urandom_range(0, 7)] : $urandom;
		b.rx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(5, 12));
		b.port_ok = $urandom_range(0, 9) != 0;
		b.bridged = $urandom_range(0, 9) == 0;
		b.pool_ok = $urandom_range(0, 7) != 0;
		if ($urandom_range(0, 19) == 0) uptime = uptime + $urandom;
		else uptime = uptime + $urandom_range(0, 300);
		b.now = ($urandom_range(0, 49) == 0) ? $urandom : uptime;
		return b;
	endfunction

	initial begin
		calm = 0;
		uptime = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = '0;
		packet_id = '0;
		rx_sf = '0;
		port_allowed = 1'b0;
		already_bridged = 1'b0;
		pool_ok = 1'b0;
		now_ms = '0;
		id_pool[0] = 32'd0;
		id_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++) id_pool[i] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no main or side factors; id 0 is a dup, other masks are empty.
		send_beat(mk(CMD_BCAST, 32'd0, 4'd5, 1, 0, 1, 32'd10));
		send_beat(mk(CMD_BCAST, 32'h11, 4'd0, 1, 0, 1, 32'd20));
		send_beat(mk(CMD_BCAST, 32'h12, 4'd3, 1, 0, 1, 32'd30));
		send_beat(mk(CMD_DM, 32'h13, 4'd15, 1, 0, 1, 32'd40));
		send_beat(mk(CMD_UNUSED, 32'h14, 4'd7, 1, 0, 1, 32'd50));
		wait_idle();
		program_regs(4'd5, 4'd12, 4'd8, 4'd0, 32'd30000);

		// Directed: drop reasons, filling all slots, then draining with ticks.
		send_beat(mk(CMD_BCAST, 32'h21, 4'd9, 1, 1, 1, 32'd100));
		send_beat(mk(CMD_BCAST, 32'hA0, 4'd9, 0, 0, 1, 32'd110));
		send_beat(mk(CMD_BCAST, 32'hA0, 4'd9, 1, 0, 1, 32'd120));
		send_beat(mk(CMD_DM, 32'hB0, 4'd5, 1, 0, 1, 32'd130));
		send_beat(mk(CMD_BCAST, 32'hC0, 4'd5, 1, 0, 1, 32'd140));
		send_beat(mk(CMD_BCAST, 32'hD0, 4'd9, 1, 0, 0, 32'd150));
		send_beat(mk(CMD_BCAST, 32'hFFFF_FFFF, 4'd15, 1, 0, 1, 32'hFFFF_FFF0));
		send_beat(mk(CMD_DM, 32'hE0, 4'd12, 1, 0, 1, 32'd160));
		send_beat(mk(CMD_BCAST, 32'hF0, 4'd10, 1, 0, 1, 32'd170));
		send_beat(mk(CMD_BCAST, 32'hFFFF_FFFF, 4'd6, 1, 0, 1, 32'd10));
		send_beat(mk(CMD_TICK, 32'd0, 4'd0, 0, 0, 0, 32'd180));
		for (int i = 0; i < 9; i++)
			send_beat(mk(CMD_TICK, 32'hFFFF_FFFF, 4'hF, 1, 1, 1, 32'hFFFF_FFFF));

		// Random phases, each under its own register settings.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: program_regs(4'd5, 4'd12, 4'd8, 4'd0, 32'd30000);
				1: program_regs(4'd12, 4'd5, 4'd12, 4'd7, 32'd100);
				2: program_regs(4'd0, 4'd15, 4'd15, 4'd15, 32'd0);
				3: program_regs(4'd9, 4'd6, 4'd9, 4'd11, 32'hFFFF_FFFF);
				default: program_regs(4'd15, 4'd8, 4'd10, 4'd5, 32'd2000);
			endcase
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				calm = (n >= 60 && n < 100);
				send_beat(random_beat());
			end
			calm = 0;
		end

		wait_idle();
		if (sb.awaited.size() != 0) begin
			$display("%0t %0d expected results never arrived", $time, sb.awaited.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("spreading_factor_fanout_scheduler_top_tb: PASS");
		end else begin
			$display("spreading_factor_fanout_scheduler_top_tb: FAIL");
		end
		$finish;
	end

endmodule
